// ----- src/kabf_pkg.sv -----
// Package for the angle/bias Kalman filter: formats, widths, reset values and saturation helpers.
`timescale 1ns / 1ps
package kabf_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int COV_FRAC_BITS   = 28;
    localparam int TIME_FRAC_BITS  = 16;

    localparam int ANGLE_W = 32;
    localparam int TIME_W  = 17;
    localparam int COV_W   = 40;
    localparam int NOISE_W = 32;
    localparam int WIDE_W  = 64;
    localparam int INNER_W = 44;
    localparam int INNOV_W = ANGLE_W + 1;

    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 96;

    // multiplier: magnitude of A times magnitude of B, B taken in 16-bit digits
    localparam int MUL_A_W    = 41;
    localparam int MUL_B_W    = INNER_W;
    localparam int MUL_DIG_W  = 16;
    localparam int MUL_DIGITS = 3;
    localparam int MUL_BM_W   = MUL_DIG_W * MUL_DIGITS;
    localparam int MUL_P_W    = MUL_A_W + MUL_BM_W;
    localparam int MUL_CNT_W  = 2;
    localparam int MAG_W      = 63;
    localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(64'h4000_0000_0000_0000);

    // gain divider: quotient held below 2^GAIN_BITS
    localparam int GAIN_BITS  = COV_W - 1;
    localparam int DIV_PRE    = GAIN_BITS - COV_FRAC_BITS;
    localparam int DIV_CNT_W  = 6;

    localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

    localparam logic [NOISE_W-1:0] QA_RESET = 32'd8053064;
    localparam logic [NOISE_W-1:0] QB_RESET = 32'd268435;
    localparam logic [NOISE_W-1:0] R_RESET  = 32'd536871;

    function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic ok;
        ok = (v[WIDE_W-1:ANGLE_W-1] == '0) || (v[WIDE_W-1:ANGLE_W-1] == '1);
        if (ok)
            sat32 = v[ANGLE_W-1:0];
        else
            sat32 = v[WIDE_W-1] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
    endfunction

    function automatic logic signed [COV_W-1:0] sat40(input logic signed [WIDE_W-1:0] v);
        logic ok;
        ok = (v[WIDE_W-1:COV_W-1] == '0) || (v[WIDE_W-1:COV_W-1] == '1);
        if (ok)
            sat40 = v[COV_W-1:0];
        else
            sat40 = v[WIDE_W-1] ? {1'b1, {(COV_W-1){1'b0}}} : {1'b0, {(COV_W-1){1'b1}}};
    endfunction

endpackage

// ----- src/kabf_mul.sv -----
// Multi-cycle signed fractional multiplier with round-to-nearest and magnitude limit.
`timescale 1ns / 1ps
module kabf_mul (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic signed [kabf_pkg::MUL_A_W-1:0]     i_a,
    input  logic signed [kabf_pkg::MUL_B_W-1:0]     i_b,
    input  logic                                    i_cov,
    output logic                                    o_done,
    output logic signed [kabf_pkg::WIDE_W-1:0]      o_res
);
    localparam int RND_W = kabf_pkg::MUL_P_W + 1;

    logic                                   r_busy;
    logic                                   r_fin;
    logic                                   r_done;
    logic [kabf_pkg::MUL_CNT_W-1:0]         r_cnt;
    logic [kabf_pkg::MUL_A_W-1:0]           r_ma;
    logic [kabf_pkg::MUL_BM_W-1:0]          r_mb;
    logic                                   r_neg;
    logic                                   r_cov;
    logic [kabf_pkg::MUL_P_W-1:0]           r_acc;
    logic signed [kabf_pkg::WIDE_W-1:0]     r_res;

    logic [kabf_pkg::MUL_A_W-1:0]           w_ma;
    logic [kabf_pkg::MUL_B_W-1:0]           w_mb;
    logic [RND_W-1:0]                       w_half;
    logic [RND_W-1:0]                       w_rnd;
    logic [RND_W-1:0]                       w_q;
    logic [kabf_pkg::MAG_W-1:0]             w_qs;

    always_comb begin
        w_ma = i_a[kabf_pkg::MUL_A_W-1] ? kabf_pkg::MUL_A_W'(-i_a) : kabf_pkg::MUL_A_W'(i_a);
        w_mb = i_b[kabf_pkg::MUL_B_W-1] ? kabf_pkg::MUL_B_W'(-i_b) : kabf_pkg::MUL_B_W'(i_b);
        w_half = r_cov ? (RND_W'(1) << (kabf_pkg::COV_FRAC_BITS - 1))
                       : (RND_W'(1) << (kabf_pkg::TIME_FRAC_BITS - 1));
        w_rnd = RND_W'(r_acc) + w_half;
        w_q = r_cov ? (w_rnd >> kabf_pkg::COV_FRAC_BITS) : (w_rnd >> kabf_pkg::TIME_FRAC_BITS);
        w_qs = (w_q > RND_W'(kabf_pkg::MAG_LIMIT)) ? kabf_pkg::MAG_LIMIT
                                                   : w_q[kabf_pkg::MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin && !i_start;
            if (i_start) begin
                r_busy <= 1'b1;
                r_fin  <= 1'b0;
                r_cnt  <= kabf_pkg::MUL_CNT_W'(kabf_pkg::MUL_DIGITS - 1);
                r_ma   <= w_ma;
                r_mb   <= kabf_pkg::MUL_BM_W'(w_mb);
                r_neg  <= i_a[kabf_pkg::MUL_A_W-1] ^ i_b[kabf_pkg::MUL_B_W-1];
                r_cov  <= i_cov;
                r_acc  <= '0;
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_busy <= 1'b0;
                r_res  <= r_neg ? -kabf_pkg::WIDE_W'(w_qs) : kabf_pkg::WIDE_W'(w_qs);
            end else if (r_busy) begin
                // top digit first, accumulator shifts up one digit per step
                r_acc <= kabf_pkg::MUL_P_W'(r_acc << kabf_pkg::MUL_DIG_W)
                       + kabf_pkg::MUL_P_W'(r_ma
                         * r_mb[kabf_pkg::MUL_BM_W-1 -: kabf_pkg::MUL_DIG_W]);
                r_mb  <= r_mb << kabf_pkg::MUL_DIG_W;
                if (r_cnt == '0)
                    r_fin <= 1'b1;
                else
                    r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- src/kabf_div.sv -----
// Restoring divider for the Kalman gain: (|p| << frac) / d, truncated and limited.
`timescale 1ns / 1ps
module kabf_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [kabf_pkg::COV_W-1:0]   i_p,
    input  logic [kabf_pkg::COV_W-1:0]          i_d,
    output logic                                o_done,
    output logic signed [kabf_pkg::COV_W-1:0]   o_q
);
    localparam int GB    = kabf_pkg::GAIN_BITS;
    localparam int REM_W = kabf_pkg::COV_W + 1;
    localparam int BIG_W = kabf_pkg::COV_W + kabf_pkg::DIV_PRE;

    logic                               r_busy;
    logic                               r_fin;
    logic                               r_done;
    logic [kabf_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [REM_W-1:0]                   r_rem;
    logic [GB-1:0]                      r_low;
    logic [GB-1:0]                      r_q;
    logic [kabf_pkg::COV_W-1:0]         r_d;
    logic                               r_neg;
    logic signed [kabf_pkg::COV_W-1:0]  r_res;

    logic [kabf_pkg::COV_W-1:0]         w_n;
    logic                               w_over;
    logic [REM_W-1:0]                   w_tr;
    logic                               w_ge;

    always_comb begin
        w_n = i_p[kabf_pkg::COV_W-1] ? kabf_pkg::COV_W'(-i_p) : kabf_pkg::COV_W'(i_p);
        w_over = BIG_W'(w_n) >= (BIG_W'(i_d) << kabf_pkg::DIV_PRE);
        w_tr = {r_rem[REM_W-2:0], r_low[GB-1]};
        w_ge = w_tr >= REM_W'(r_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin && !i_start;
            if (i_start) begin
                r_neg <= i_p[kabf_pkg::COV_W-1];
                r_d   <= i_d;
                r_rem <= REM_W'(w_n >> kabf_pkg::DIV_PRE);
                r_low <= GB'(w_n) << kabf_pkg::COV_FRAC_BITS;
                r_cnt <= kabf_pkg::DIV_CNT_W'(GB - 1);
                if (w_over) begin
                    r_q    <= '1;
                    r_fin  <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_q    <= '0;
                    r_fin  <= 1'b0;
                    r_busy <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_res  <= r_neg ? -kabf_pkg::COV_W'(r_q) : kabf_pkg::COV_W'(r_q);
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_tr - REM_W'(r_d)) : w_tr;
                r_q   <= {r_q[GB-2:0], w_ge};
                r_low <= r_low << 1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_res;

endmodule

// ----- src/kalman_angle_bias_filter.sv -----
// Top level of the two-state angle/gyro-bias Kalman filter with its sequencer.
`timescale 1ns / 1ps
// One request on s_axis carries an accelerometer angle, a gyro rate and a time step; one
// response on m_axis carries the filtered angle, the bias estimate and the unbiased rate.
// Each request takes ten multiplies on the shared 41x16-per-cycle multiplier, two gain
// divisions on the one-bit-per-cycle divider, an accept step and an output load step; the
// divisions are skipped when the innovation variance is not positive. The final load waits
// until the output register is free. s_axis_tready is high only between requests; a
// finished response waits in the output register while the next request is worked on.
// Noise registers are written on the cfg port, which is always ready. The user must write
// them only while the filter is idle; the block itself does not enforce this.
module kalman_angle_bias_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // measured_angle [31:0], measured_rate [63:32], time_step [80:64], zero [87:81]
    input  logic [kabf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // filtered_angle [31:0], bias_estimate [63:32], unbiased_rate [95:64]
    output logic [kabf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kabf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kabf_pkg::NOISE_W-1:0]        i_cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    typedef enum logic [3:0] {
        OP_PRED_ANGLE,
        OP_PRED_T,
        OP_PRED_P00,
        OP_PRED_P11,
        OP_CORR_ANGLE,
        OP_CORR_BIAS,
        OP_UPD_P10,
        OP_UPD_P11,
        OP_UPD_P01,
        OP_UPD_P00
    } t_op;

    localparam int AW = kabf_pkg::ANGLE_W;
    localparam int CW = kabf_pkg::COV_W;
    localparam int WW = kabf_pkg::WIDE_W;

    t_state                             r_state;
    t_op                                r_op;
    logic                               r_dop;
    logic                               r_issue;

    logic [kabf_pkg::NOISE_W-1:0]       r_qa;
    logic [kabf_pkg::NOISE_W-1:0]       r_qb;
    logic [kabf_pkg::NOISE_W-1:0]       r_r;

    logic signed [AW-1:0]               r_angle;
    logic signed [AW-1:0]               r_bias;
    logic signed [CW-1:0]               r_p0;
    logic signed [CW-1:0]               r_p1;
    logic signed [CW-1:0]               r_p2;
    logic signed [CW-1:0]               r_p3;

    logic signed [AW-1:0]               r_z;
    logic [kabf_pkg::TIME_W-1:0]        r_dt;
    logic signed [AW-1:0]               r_rate;
    logic signed [kabf_pkg::INNER_W-1:0] r_inner;
    logic signed [kabf_pkg::INNOV_W-1:0] r_y;
    logic [CW-1:0]                      r_d;
    logic signed [CW-1:0]               r_k0;
    logic signed [CW-1:0]               r_k1;

    logic                               r_ovalid;
    logic [kabf_pkg::OUT_DATA_W-1:0]    r_odata;

    logic signed [kabf_pkg::MUL_A_W-1:0] w_ma;
    logic signed [kabf_pkg::MUL_B_W-1:0] w_mb;
    logic                               w_mcov;
    logic                               w_mdone;
    logic signed [WW-1:0]               w_mres;
    logic                               w_ddone;
    logic signed [CW-1:0]               w_dq;

    logic signed [AW-1:0]               w_in_rate;
    logic signed [WW-1:0]               w_rate_diff;
    logic signed [CW:0]                 w_s;
    logic                               w_s_pos;
    logic signed [WW-1:0]               w_qa_s;

    always_comb begin
        w_in_rate   = $signed(s_axis_tdata[2*AW-1:AW]);
        w_rate_diff = WW'(w_in_rate) - WW'(r_bias);
        w_s         = (CW+1)'(r_p0) + $signed((CW+1)'(r_r));
        w_s_pos     = !w_s[CW] && (w_s != '0);
        w_qa_s      = $signed(WW'(r_qa));
    end

    always_comb begin
        w_mcov = 1'b1;
        case (r_op)
            OP_PRED_ANGLE: begin
                w_ma = $signed(kabf_pkg::MUL_A_W'(r_dt));
                w_mb = kabf_pkg::MUL_B_W'(r_rate);
                w_mcov = 1'b0;
            end
            OP_PRED_T: begin
                w_ma = $signed(kabf_pkg::MUL_A_W'(r_dt));
                w_mb = kabf_pkg::MUL_B_W'(r_p3);
                w_mcov = 1'b0;
            end
            OP_PRED_P00: begin
                w_ma = $signed(kabf_pkg::MUL_A_W'(r_dt));
                w_mb = r_inner;
                w_mcov = 1'b0;
            end
            OP_PRED_P11: begin
                w_ma = $signed(kabf_pkg::MUL_A_W'(r_qb));
                w_mb = $signed(kabf_pkg::MUL_B_W'(r_dt));
                w_mcov = 1'b0;
            end
            OP_CORR_ANGLE: begin
                w_ma = kabf_pkg::MUL_A_W'(r_k0);
                w_mb = kabf_pkg::MUL_B_W'(r_y);
            end
            OP_CORR_BIAS: begin
                w_ma = kabf_pkg::MUL_A_W'(r_k1);
                w_mb = kabf_pkg::MUL_B_W'(r_y);
            end
            OP_UPD_P10: begin
                w_ma = kabf_pkg::MUL_A_W'(r_k1);
                w_mb = kabf_pkg::MUL_B_W'(r_p0);
            end
            OP_UPD_P11: begin
                w_ma = kabf_pkg::MUL_A_W'(r_k1);
                w_mb = kabf_pkg::MUL_B_W'(r_p1);
            end
            OP_UPD_P01: begin
                w_ma = kabf_pkg::MUL_A_W'(r_k0);
                w_mb = kabf_pkg::MUL_B_W'(r_p1);
            end
            OP_UPD_P00: begin
                w_ma = kabf_pkg::MUL_A_W'(r_k0);
                w_mb = kabf_pkg::MUL_B_W'(r_p0);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    kabf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_issue && (r_state == S_MUL)),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .i_cov   (w_mcov),
        .o_done  (w_mdone),
        .o_res   (w_mres)
    );

    kabf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_issue && (r_state == S_DIV)),
        .i_p     (r_dop ? r_p2 : r_p0),
        .i_d     (r_d),
        .o_done  (w_ddone),
        .o_q     (w_dq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= kabf_pkg::QA_RESET;
            r_qb <= kabf_pkg::QB_RESET;
            r_r  <= kabf_pkg::R_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                kabf_pkg::REG_ANGLE_NOISE: r_qa <= i_cfg_data;
                kabf_pkg::REG_BIAS_NOISE:  r_qb <= i_cfg_data;
                kabf_pkg::REG_MEAS_NOISE:  r_r  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_PRED_ANGLE;
            r_dop    <= 1'b0;
            r_issue  <= 1'b0;
            r_ovalid <= 1'b0;
            r_angle  <= AW'(1) << kabf_pkg::ANGLE_FRAC_BITS;
            r_bias   <= '0;
            r_p0     <= '0;
            r_p1     <= '0;
            r_p2     <= '0;
            r_p3     <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready && (r_state != S_FIN))
                r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_issue <= s_axis_tvalid;
                    if (s_axis_tvalid) begin
                        r_z     <= $signed(s_axis_tdata[AW-1:0]);
                        r_dt    <= s_axis_tdata[2*AW +: kabf_pkg::TIME_W];
                        r_rate  <= kabf_pkg::sat32(w_rate_diff);
                        r_op    <= OP_PRED_ANGLE;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_issue <= w_mdone && (r_op != OP_UPD_P00);
                    if (w_mdone) begin
                        r_op    <= t_op'(r_op + 1'b1);
                        case (r_op)
                            OP_PRED_ANGLE: r_angle <= kabf_pkg::sat32(WW'(r_angle) + w_mres);
                            OP_PRED_T: begin
                                r_inner <= kabf_pkg::INNER_W'(w_mres - WW'(r_p1)
                                           - WW'(r_p2) + w_qa_s);
                                r_p1 <= kabf_pkg::sat40(WW'(r_p1) - w_mres);
                                r_p2 <= kabf_pkg::sat40(WW'(r_p2) - w_mres);
                            end
                            OP_PRED_P00: r_p0 <= kabf_pkg::sat40(WW'(r_p0) + w_mres);
                            OP_PRED_P11: begin
                                r_p3 <= kabf_pkg::sat40(WW'(r_p3) + w_mres);
                                r_y  <= kabf_pkg::INNOV_W'(r_z) - kabf_pkg::INNOV_W'(r_angle);
                                if (w_s_pos) begin
                                    r_d     <= w_s[CW-1:0];
                                    r_dop   <= 1'b0;
                                    r_state <= S_DIV;
                                end else begin
                                    r_k0 <= '0;
                                    r_k1 <= '0;
                                end
                            end
                            OP_CORR_ANGLE: r_angle <= kabf_pkg::sat32(WW'(r_angle) + w_mres);
                            OP_CORR_BIAS:  r_bias  <= kabf_pkg::sat32(WW'(r_bias) + w_mres);
                            OP_UPD_P10:    r_p2 <= kabf_pkg::sat40(WW'(r_p2) - w_mres);
                            OP_UPD_P11:    r_p3 <= kabf_pkg::sat40(WW'(r_p3) - w_mres);
                            OP_UPD_P01:    r_p1 <= kabf_pkg::sat40(WW'(r_p1) - w_mres);
                            OP_UPD_P00: begin
                                r_p0    <= kabf_pkg::sat40(WW'(r_p0) - w_mres);
                                r_state <= S_FIN;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_DIV: begin
                    r_issue <= w_ddone;
                    if (w_ddone) begin
                        if (!r_dop) begin
                            r_k0  <= w_dq;
                            r_dop <= 1'b1;
                        end else begin
                            r_k1    <= w_dq;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_FIN: begin
                    r_issue <= 1'b0;
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata  <= {r_rate, r_bias, r_angle};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_issue <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign o_cfg_ready   = 1'b1;

endmodule

// ----- src/kabf_chk.sv -----
// Port-level checker for the Kalman filter, bound to the top level.
`timescale 1ns / 1ps
module kabf_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [kabf_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted request");

    a_no_instant_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("response appeared one cycle after request");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("response dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("response data changed while stalled");

endmodule

bind kalman_angle_bias_filter kabf_chk u_kabf_chk (.*);
